// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the servo bus packet engine RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`endif

// File: rtl/sbpe_pkg.sv
// ---------------------------------------------------------------------------
// Servo bus packet engine package
// Types, codes and constants shared by the packet engine modules.
// ---------------------------------------------------------------------------
package sbpe_pkg;

  // Protocol limits.
  localparam int unsigned MaxParams  = 64;
  localparam int unsigned MaxRead    = 64;
  localparam int unsigned MaxResults = 6;

  localparam int unsigned CntW      = 7;
  localparam int unsigned BurstCntW = $clog2(MaxResults + 1);

  // Packet framing.
  localparam logic [7:0] SyncByte    = 8'hFF;
  localparam logic [7:0] LenOverhead = 8'd2;

  // Reply byte positions.
  localparam logic [CntW-1:0] RxPosId    = CntW'(2);
  localparam logic [CntW-1:0] RxPosErr   = CntW'(4);
  localparam logic [CntW-1:0] RxPosData  = CntW'(5);

  // Stream widths.
  localparam int unsigned TdataInW  = 40;
  localparam int unsigned TdataOutW = 24;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_PARAM   = 2'd1,
    OP_RX_BYTE = 2'd2,
    OP_TIMEOUT = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_TX     = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef struct packed {
    opcode_e         opcode;
    logic [7:0]      target_id;
    logic [7:0]      instruction;
    logic [CntW-1:0] param_count;
    logic [CntW-1:0] expect_count;
    logic [7:0]      data_byte;
  } item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    logic       last;
    logic [7:0] servo_error;
    logic       timeout_flag;
    logic       header_fail;
    logic       id_mismatch;
    logic       checksum_bad;
  } result_t;

  // Results caused by one item, first result in entry zero.
  typedef struct packed {
    logic [BurstCntW-1:0]         count;
    result_t [MaxResults-1:0]     ent;
  } burst_t;

  // Result carrying one byte for the bus.
  function automatic result_t tx_result(input logic [7:0] value, input logic is_last);
    result_t r;
    r              = '0;
    r.kind         = KIND_TX;
    r.out_byte     = value;
    r.last         = is_last;
    return r;
  endfunction

endpackage

// File: rtl/sbpe_txn.sv
// ---------------------------------------------------------------------------
// Servo bus transaction sequencer
// Holds the transaction state and forms the results of one accepted item.
// ---------------------------------------------------------------------------
module sbpe_txn (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  sbpe_pkg::item_t  item_i,
  output sbpe_pkg::burst_t burst_o
);
  import sbpe_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SEND = 2'd1,
    PH_RECV = 2'd2
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [7:0]      saved_id_q, saved_id_d;
  logic [7:0]      tx_sum_q, tx_sum_d;
  logic [CntW-1:0] params_left_q, params_left_d;
  logic [CntW-1:0] rx_pos_q, rx_pos_d;
  logic [CntW-1:0] rx_exp_q, rx_exp_d;
  logic [7:0]      rx_sum_q, rx_sum_d;
  logic            header_ok_q, header_ok_d;
  logic            id_ok_q, id_ok_d;
  logic [7:0]      servo_err_q, servo_err_d;

  logic [CntW-1:0] pc_sat;
  logic [CntW-1:0] ec_sat;
  logic [7:0]      len;
  logic [7:0]      start_sum;
  logic [7:0]      param_sum;
  logic [CntW-1:0] params_next;
  logic [7:0]      data_end;
  logic [7:0]      rx_sum_add;
  result_t         status;

  // Counts from a start item are clipped to the protocol limits.
  assign pc_sat     = (item_i.param_count > CntW'(MaxParams)) ? CntW'(MaxParams)
                                                              : item_i.param_count;
  assign ec_sat     = (item_i.expect_count > CntW'(MaxRead)) ? CntW'(MaxRead)
                                                             : item_i.expect_count;
  assign len        = {1'b0, pc_sat} + LenOverhead;
  assign start_sum  = item_i.target_id + len + item_i.instruction;
  assign param_sum  = tx_sum_q + item_i.data_byte;
  assign params_next = (params_left_q != '0) ? params_left_q - CntW'(1) : '0;
  assign data_end   = {1'b0, RxPosData} + {1'b0, rx_exp_q};
  assign rx_sum_add = rx_sum_q + item_i.data_byte;

  // Status summary built from the flags gathered so far.
  always_comb begin
    status             = '0;
    status.kind        = KIND_STATUS;
    status.last        = 1'b1;
    status.servo_error = servo_err_q;
    status.header_fail = ~header_ok_q;
    status.id_mismatch = ~id_ok_q;
  end

  // Next state and results of the current item.
  always_comb begin
    phase_d       = phase_q;
    saved_id_d    = saved_id_q;
    tx_sum_d      = tx_sum_q;
    params_left_d = params_left_q;
    rx_pos_d      = rx_pos_q;
    rx_exp_d      = rx_exp_q;
    rx_sum_d      = rx_sum_q;
    header_ok_d   = header_ok_q;
    id_ok_d       = id_ok_q;
    servo_err_d   = servo_err_q;
    burst_o       = '0;

    unique case (item_i.opcode)
      OP_START: begin
        saved_id_d    = item_i.target_id;
        params_left_d = pc_sat;
        rx_exp_d      = ec_sat;
        rx_pos_d      = '0;
        rx_sum_d      = '0;
        header_ok_d   = 1'b1;
        id_ok_d       = 1'b1;
        servo_err_d   = '0;
        tx_sum_d      = start_sum;
        burst_o.ent[0] = tx_result(SyncByte, 1'b0);
        burst_o.ent[1] = tx_result(SyncByte, 1'b0);
        burst_o.ent[2] = tx_result(item_i.target_id, 1'b0);
        burst_o.ent[3] = tx_result(len, 1'b0);
        burst_o.ent[4] = tx_result(item_i.instruction, 1'b0);
        if (pc_sat == '0) begin
          burst_o.ent[5] = tx_result(~start_sum, 1'b1);
          burst_o.count  = BurstCntW'(6);
          phase_d        = PH_RECV;
        end else begin
          burst_o.count  = BurstCntW'(5);
          phase_d        = PH_SEND;
        end
      end
      OP_PARAM: begin
        if (phase_q == PH_SEND) begin
          tx_sum_d       = param_sum;
          params_left_d  = params_next;
          burst_o.ent[0] = tx_result(item_i.data_byte, 1'b0);
          if (params_next == '0) begin
            burst_o.ent[1] = tx_result(~param_sum, 1'b1);
            burst_o.count  = BurstCntW'(2);
            phase_d        = PH_RECV;
            rx_pos_d       = '0;
            rx_sum_d       = '0;
          end else begin
            burst_o.count  = BurstCntW'(1);
          end
        end
      end
      OP_TIMEOUT: begin
        if (phase_q == PH_RECV) begin
          burst_o.ent[0]              = status;
          burst_o.ent[0].timeout_flag = 1'b1;
          burst_o.count               = BurstCntW'(1);
          phase_d                     = PH_IDLE;
        end
      end
      OP_RX_BYTE: begin
        if (phase_q == PH_RECV) begin
          priority if (rx_pos_q < RxPosId) begin
            // Two sync bytes open the reply.
            if (item_i.data_byte != SyncByte) begin
              header_ok_d = 1'b0;
            end
            rx_pos_d = rx_pos_q + CntW'(1);
          end else if (rx_pos_q < RxPosData) begin
            // Id, length and error byte enter the checksum.
            if ((rx_pos_q == RxPosId) && (item_i.data_byte != saved_id_q)) begin
              id_ok_d = 1'b0;
            end
            if (rx_pos_q == RxPosErr) begin
              servo_err_d = item_i.data_byte;
            end
            rx_sum_d = rx_sum_add;
            rx_pos_d = rx_pos_q + CntW'(1);
          end else if ({1'b0, rx_pos_q} < data_end) begin
            // Reply data is passed straight out.
            rx_sum_d                = rx_sum_add;
            rx_pos_d                = rx_pos_q + CntW'(1);
            burst_o.ent[0]          = '0;
            burst_o.ent[0].kind     = KIND_DATA;
            burst_o.ent[0].out_byte = item_i.data_byte;
            burst_o.count           = BurstCntW'(1);
          end else begin
            // Checksum byte closes the transaction.
            burst_o.ent[0]              = status;
            burst_o.ent[0].checksum_bad = (item_i.data_byte != ~rx_sum_q);
            burst_o.count               = BurstCntW'(1);
            phase_d                     = PH_IDLE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Transaction state, updated on every accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      saved_id_q    <= '0;
      tx_sum_q      <= '0;
      params_left_q <= '0;
      rx_pos_q      <= '0;
      rx_exp_q      <= '0;
      rx_sum_q      <= '0;
      header_ok_q   <= 1'b1;
      id_ok_q       <= 1'b1;
      servo_err_q   <= '0;
    end else if (accept_i) begin
      phase_q       <= phase_d;
      saved_id_q    <= saved_id_d;
      tx_sum_q      <= tx_sum_d;
      params_left_q <= params_left_d;
      rx_pos_q      <= rx_pos_d;
      rx_exp_q      <= rx_exp_d;
      rx_sum_q      <= rx_sum_d;
      header_ok_q   <= header_ok_d;
      id_ok_q       <= id_ok_d;
      servo_err_q   <= servo_err_d;
    end
  end

endmodule

// File: rtl/servo_bus_packet_engine_core.sv
// ---------------------------------------------------------------------------
// Servo bus packet engine
// Host side of one servo bus transaction: builds the command packet and
// parses the status reply, one stream transfer per byte.
//
//   Channel  Dir  Carries
//   s_axis   in   tuser: opcode; tdata: id, instruction, counts, data byte
//   m_axis   out  tuser: kind; tdata: byte and flags; tlast: packet end
//
// An item's results (up to six) are loaded into an output queue and leave
// one per cycle while m_axis is ready, so the input rate is set by the
// output port: an item has one result or none, the last parameter byte
// two (byte and checksum), a start item five or six.
// A new item is taken in the same cycle that the last queued result leaves.
// Reset clears the queue and returns the transaction to idle.
// Back-pressure on m_axis holds the queue and, through it, s_axis.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module servo_bus_packet_engine_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] target_id, [15:8] instruction, [22:16] param_count,
  // [29:23] expect_count, [37:30] data_byte, [39:38] zero
  input  logic [sbpe_pkg::TdataInW-1:0] s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] out_byte, [15:8] servo_error, [16] timeout_flag, [17] header_fail,
  // [18] id_mismatch, [19] checksum_bad, [23:20] zero
  output logic [sbpe_pkg::TdataOutW-1:0] m_axis_tdata,
  // [1:0] kind
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);
  import sbpe_pkg::*;

  item_t                    item;
  burst_t                   txn_burst;
  logic                     s_xfer;
  logic                     m_xfer;
  logic [BurstCntW-1:0]     out_cnt_q, out_cnt_d;
  result_t [MaxResults-1:0] ent_q, ent_d;
  result_t                  head;

  // Input item unpacking.
  always_comb begin
    item.opcode       = opcode_e'(s_axis_tuser);
    item.target_id    = s_axis_tdata[7:0];
    item.instruction  = s_axis_tdata[15:8];
    item.param_count  = s_axis_tdata[22:16];
    item.expect_count = s_axis_tdata[29:23];
    item.data_byte    = s_axis_tdata[37:30];
  end

  // Handshake: the queue is free once its last result is leaving.
  assign m_xfer        = m_axis_tvalid & m_axis_tready;
  assign s_axis_tready = (out_cnt_q == '0) ||
                         ((out_cnt_q == BurstCntW'(1)) && m_axis_tready);
  assign s_xfer        = s_axis_tvalid & s_axis_tready;

  sbpe_txn u_txn (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (s_xfer),
    .item_i   (item),
    .burst_o  (txn_burst)
  );

  // Output queue: shift toward entry zero on each output transfer.
  always_comb begin
    out_cnt_d = out_cnt_q;
    ent_d     = ent_q;
    if (m_xfer) begin
      out_cnt_d = out_cnt_q - BurstCntW'(1);
      for (int i = 0; i < MaxResults - 1; i++) begin
        ent_d[i] = ent_q[i+1];
      end
      ent_d[MaxResults-1] = '0;
    end
    if (s_xfer) begin
      out_cnt_d = txn_burst.count;
      ent_d     = txn_burst.ent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_cnt_q <= '0;
    end else begin
      out_cnt_q <= out_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  // Output packing from the queue head.
  assign head          = ent_q[0];
  assign m_axis_tvalid = (out_cnt_q != '0);
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;
  assign m_axis_tdata  = {4'b0000, head.checksum_bad, head.id_mismatch,
                          head.header_fail, head.timeout_flag,
                          head.servo_error, head.out_byte};

  // An item is only taken when at most one result is still queued.
  `ASSERT_IMPLY(a_accept_queue_low, clk_i, rst_ni, s_xfer,
                (out_cnt_q == '0) || (out_cnt_q == BurstCntW'(1)))
  // A status result always closes its packet.
  `ASSERT_IMPLY(a_status_last, clk_i, rst_ni,
                m_axis_tvalid && (m_axis_tuser == KIND_STATUS), m_axis_tlast)
  // Without a new item, each output transfer drains exactly one entry.
  `ASSERT_NEXT(a_drain_one, clk_i, rst_ni, m_xfer && !s_xfer,
               out_cnt_q == ($past(out_cnt_q) - BurstCntW'(1)))

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Servo bus packet engine testbench
// Drives command, parameter, received-byte and timeout transfers into the
// packet engine. A behavioral model of the transaction builds the command
// packet and parses the reply to predict every outgoing transfer. A short
// directed table comes first, then random transactions with corrupted,
// truncated and abandoned replies. Both stream sides stall at random.
// ---------------------------------------------------------------------------
module testbench;
  import sbpe_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEND,
    ST_RECV
  } txn_phase_e;

  // One row of the directed table; typed_res, when enabled, replaces the
  // last predicted result of that item.
  typedef struct {
    opcode_e         op;
    logic [7:0]      id;
    logic [7:0]      ins;
    logic [CntW-1:0] pc;
    logic [CntW-1:0] ec;
    logic [7:0]      dbyte;
    logic            typed_on;
    result_t         typed_res;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [TdataInW-1:0]  s_axis_tdata;
  logic [1:0]           s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [TdataOutW-1:0] m_axis_tdata;
  logic [1:0]           m_axis_tuser;
  logic                 m_axis_tlast;

  // Expected outgoing transfers, oldest first.
  result_t due_outputs [$];

  // Item currently offered on the input stream.
  item_t   drv_item;
  logic    drv_typed_on;
  result_t drv_typed_val;

  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned stall_left;
  bit          calm;

  // Transaction state of the model.
  txn_phase_e      txn_phase;
  logic [7:0]      cmd_id;
  logic [7:0]      cmd_sum;
  logic [CntW-1:0] params_due;
  logic [CntW-1:0] reply_pos;
  logic [CntW-1:0] reply_data_cnt;
  logic [7:0]      reply_sum;
  logic            reply_hdr_ok;
  logic            reply_id_ok;
  logic [7:0]      reply_err;

  dir_row_t directed_rows [23] = '{
    // Parameter, received byte and timeout are dropped while idle.
    '{OP_PARAM,   8'h00, 8'h00, 7'd0, 7'd0, 8'hFF, 1'b0, '0},
    '{OP_RX_BYTE, 8'h00, 8'h00, 7'd0, 7'd0, 8'hFF, 1'b0, '0},
    '{OP_TIMEOUT, 8'h00, 8'h00, 7'd0, 7'd0, 8'h00, 1'b0, '0},
    // No parameters: the checksum follows the header at once.
    '{OP_START,   8'h01, 8'h02, 7'd0, 7'd0, 8'h00, 1'b1,
      '{KIND_TX, 8'hFA, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{OP_PARAM,   8'h00, 8'h00, 7'd0, 7'd0, 8'h55, 1'b0, '0},
    // Timeout before any reply byte.
    '{OP_TIMEOUT, 8'h00, 8'h00, 7'd0, 7'd0, 8'h00, 1'b1,
      '{KIND_STATUS, 8'h00, 1'b1, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0}},
    // A new start while parameters are still due abandons the old command.
    '{OP_START,   8'hFF, 8'hFF, 7'd2, 7'd1, 8'h00, 1'b0, '0},
    '{OP_START,   8'h00, 8'h00, 7'd1, 7'd1, 8'h00, 1'b0, '0},
    '{OP_PARAM,   8'h00, 8'h00, 7'd0, 7'd0, 8'hFF, 1'b0, '0},
    // Clean reply with one data byte and an error byte of all ones.
    '{OP_RX_BYTE, 8'h00, 8'h00, 7'd0, 7'd0, 8'hFF, 1'b0, '0},
    '{OP_RX_BYTE, 8'h00, 8'h00, 7'd0, 7'd0, 8'hFF, 1'b0, '0},
    '{OP_RX_BYTE, 8'h00, 8'h00, 7'd0, 7'd0, 8'h00, 1'b0, '0},
    '{OP_RX_BYTE, 8'h00, 8'h00, 7'd0, 7'd0, 8'h03, 1'b0, '0},
    '{OP_RX_BYTE, 8'h00, 8'h00, 7'd0, 7'd0, 8'hFF, 1'b0, '0},
    '{OP_RX_BYTE, 8'h00, 8'h00, 7'd0, 7'd0, 8'h00, 1'b0, '0},
    '{OP_RX_BYTE, 8'h00, 8'h00, 7'd0, 7'd0, 8'hFD, 1'b1,
      '{KIND_STATUS, 8'h00, 1'b1, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0}},
    // Reply with a bad header, a wrong id and a wrong checksum.
    '{OP_START,   8'h05, 8'h80, 7'd0, 7'd0, 8'h00, 1'b0, '0},
    '{OP_RX_BYTE, 8'h00, 8'h00, 7'd0, 7'd0, 8'h00, 1'b0, '0},
    '{OP_RX_BYTE, 8'h00, 8'h00, 7'd0, 7'd0, 8'hFF, 1'b0, '0},
    '{OP_RX_BYTE, 8'h00, 8'h00, 7'd0, 7'd0, 8'h06, 1'b0, '0},
    '{OP_RX_BYTE, 8'h00, 8'h00, 7'd0, 7'd0, 8'h02, 1'b0, '0},
    '{OP_RX_BYTE, 8'h00, 8'h00, 7'd0, 7'd0, 8'h00, 1'b0, '0},
    '{OP_RX_BYTE, 8'h00, 8'h00, 7'd0, 7'd0, 8'h00, 1'b1,
      '{KIND_STATUS, 8'h00, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1}}
  };

  servo_bus_packet_engine_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard limit on run time.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Transaction model
  // ---------------------------------------------------------------------

  task automatic push_tx(input logic [7:0] value, input logic is_last);
    result_t r;
    r          = '0;
    r.kind     = KIND_TX;
    r.out_byte = value;
    r.last     = is_last;
    due_outputs.push_back(r);
  endtask

  task automatic push_status(input logic timed_out, input logic sum_bad);
    result_t r;
    r              = '0;
    r.kind         = KIND_STATUS;
    r.last         = 1'b1;
    r.servo_error  = reply_err;
    r.timeout_flag = timed_out;
    r.header_fail  = ~reply_hdr_ok;
    r.id_mismatch  = ~reply_id_ok;
    r.checksum_bad = sum_bad;
    due_outputs.push_back(r);
    txn_phase = ST_IDLE;
  endtask

  // Send the command checksum and switch over to reply parsing.
  task automatic close_command();
    push_tx(~cmd_sum, 1'b1);
    txn_phase = ST_RECV;
    reply_pos = '0;
    reply_sum = '0;
  endtask

  // Work out the transfers that one accepted item causes.
  task automatic predict_packet_output(input item_t it);
    logic [CntW-1:0] pc;
    logic [CntW-1:0] ec;
    logic [7:0]      len;
    result_t         r;
    if (it.opcode == OP_START) begin
      pc = (it.param_count > MaxParams) ? CntW'(MaxParams) : it.param_count;
      ec = (it.expect_count > MaxRead) ? CntW'(MaxRead) : it.expect_count;
      len            = 8'(pc) + LenOverhead;
      cmd_id         = it.target_id;
      params_due     = pc;
      reply_data_cnt = ec;
      reply_pos      = '0;
      reply_sum      = '0;
      reply_hdr_ok   = 1'b1;
      reply_id_ok    = 1'b1;
      reply_err      = '0;
      cmd_sum        = it.target_id + len + it.instruction;
      push_tx(SyncByte, 1'b0);
      push_tx(SyncByte, 1'b0);
      push_tx(it.target_id, 1'b0);
      push_tx(len, 1'b0);
      push_tx(it.instruction, 1'b0);
      if (pc == 0) begin
        close_command();
      end else begin
        txn_phase = ST_SEND;
      end
    end else if (it.opcode == OP_PARAM) begin
      if (txn_phase == ST_SEND) begin
        push_tx(it.data_byte, 1'b0);
        cmd_sum = cmd_sum + it.data_byte;
        if (params_due > 0) params_due--;
        if (params_due == 0) close_command();
      end
    end else if (txn_phase == ST_RECV) begin
      if (it.opcode == OP_TIMEOUT) begin
        push_status(1'b1, 1'b0);
      end else if (reply_pos < RxPosId) begin
        // Two sync bytes lead the reply.
        if (it.data_byte != SyncByte) reply_hdr_ok = 1'b0;
        reply_pos++;
      end else if (reply_pos < RxPosData) begin
        // Id, length and error byte; the length is summed but not checked.
        if (reply_pos == RxPosId && it.data_byte != cmd_id) reply_id_ok = 1'b0;
        if (reply_pos == RxPosErr) reply_err = it.data_byte;
        reply_sum = reply_sum + it.data_byte;
        reply_pos++;
      end else if (int'(reply_pos) < int'(RxPosData) + int'(reply_data_cnt)) begin
        reply_sum = reply_sum + it.data_byte;
        reply_pos++;
        r          = '0;
        r.kind     = KIND_DATA;
        r.out_byte = it.data_byte;
        due_outputs.push_back(r);
      end else begin
        push_status(1'b0, it.data_byte != 8'(~reply_sum));
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  task automatic check_field(input string name, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
      fail_count++;
    end
  endtask

  // Predict on each accepted input transfer, then check each output
  // transfer against the oldest expectation.
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_packet_output(drv_item);
        if (drv_typed_on && due_outputs.size() > 0) begin
          due_outputs[due_outputs.size() - 1] = drv_typed_val;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind         = kind_e'(m_axis_tuser);
        got.out_byte     = m_axis_tdata[7:0];
        got.last         = m_axis_tlast;
        got.servo_error  = m_axis_tdata[15:8];
        got.timeout_flag = m_axis_tdata[16];
        got.header_fail  = m_axis_tdata[17];
        got.id_mismatch  = m_axis_tdata[18];
        got.checksum_bad = m_axis_tdata[19];
        if (due_outputs.size() == 0) begin
          $error("unexpected output transfer: kind %0d byte 0x%0h",
                 m_axis_tuser, m_axis_tdata[7:0]);
          fail_count++;
        end else begin
          want = due_outputs.pop_front();
          check_field("kind", want.kind, got.kind);
          check_field("out_byte", want.out_byte, got.out_byte);
          check_field("last", want.last, got.last);
          check_field("servo_error", want.servo_error, got.servo_error);
          check_field("timeout_flag", want.timeout_flag, got.timeout_flag);
          check_field("header_fail", want.header_fail, got.header_fail);
          check_field("id_mismatch", want.id_mismatch, got.id_mismatch);
          check_field("checksum_bad", want.checksum_bad, got.checksum_bad);
        end
      end
    end
  end

  // Output back-pressure: a random stall after each output transfer.
  initial begin
    m_axis_tready = 1'b0;
    stall_left    = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        stall_left = calm ? 0 : $urandom_range(0, 4);
      end
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  // Offer one item after a random gap and hold it until it is taken.
  task automatic send_item(input item_t it, input logic typed_on,
                           input result_t typed_val);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    drv_item      = it;
    drv_typed_on  = typed_on;
    drv_typed_val = typed_val;
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = it.opcode;
    s_axis_tdata  = {2'b00, it.data_byte, it.expect_count, it.param_count,
                     it.instruction, it.target_id};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Hold off the sender until every expected transfer has come out.
  task automatic wait_for_drain();
    s_axis_tvalid = 1'b0;
    while (due_outputs.size() != 0) @(negedge clk_i);
  endtask

  // Item with every field random; callers set the fields that matter.
  function automatic item_t random_item(input opcode_e op);
    item_t it;
    it.opcode       = op;
    it.target_id    = 8'($urandom);
    it.instruction  = 8'($urandom);
    it.param_count  = CntW'($urandom);
    it.expect_count = CntW'($urandom);
    it.data_byte    = 8'($urandom);
    return it;
  endfunction

  // Mostly short counts, sometimes the top of the range or beyond it.
  function automatic logic [CntW-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 15) return CntW'($urandom_range(0, 6));
    if (r < 18) return CntW'($urandom_range(7, 40));
    if (r == 18) return CntW'($urandom_range(60, 64));
    return CntW'($urandom_range(65, 127));
  endfunction

  // Now and then an item that the current phase should drop.
  task automatic send_noise(input bit sending);
    opcode_e op;
    if ($urandom_range(0, 14) == 0) begin
      if (sending) begin
        op = $urandom_range(0, 1) ? OP_RX_BYTE : OP_TIMEOUT;
      end else begin
        op = OP_PARAM;
      end
      send_item(random_item(op), 1'b0, '0);
    end
  endtask

  // One full transaction: command, parameters and a reply that may be
  // corrupted, cut short by a timeout, or abandoned by the next start.
  task automatic run_transaction();
    item_t           it;
    logic [CntW-1:0] pc;
    logic [CntW-1:0] ec;
    logic [7:0]      id;
    logic [7:0]      sum;
    logic [7:0]      csum;
    logic [7:0]      reply [$];
    int              n_par;
    int              n_data;
    int              cut;
    bit              abandon;
    calm    = ($urandom_range(0, 4) == 0);
    abandon = ($urandom_range(0, 11) == 0);
    id      = 8'($urandom_range(0, 255));
    pc      = pick_count();
    ec      = pick_count();
    it              = random_item(OP_START);
    it.target_id    = id;
    it.param_count  = pc;
    it.expect_count = ec;
    send_item(it, 1'b0, '0);

    n_par = (pc > MaxParams) ? MaxParams : pc;
    for (int i = 0; i < n_par; i++) begin
      if (abandon && i == n_par / 2) return;
      send_noise(1'b1);
      send_item(random_item(OP_PARAM), 1'b0, '0);
    end

    // Build the reply, then damage it at random.
    n_data = (ec > MaxRead) ? MaxRead : ec;
    reply.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 254)) : SyncByte);
    reply.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 254)) : SyncByte);
    reply.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : id);
    reply.push_back(8'(n_data) + LenOverhead);
    reply.push_back(($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255)) : 8'h00);
    sum = reply[2] + reply[3] + reply[4];
    for (int i = 0; i < n_data; i++) begin
      reply.push_back(8'($urandom));
      sum = sum + reply[reply.size() - 1];
    end
    csum = ~sum;
    if ($urandom_range(0, 7) == 0) csum = csum ^ 8'($urandom_range(1, 255));
    reply.push_back(csum);

    cut = reply.size();
    if (abandon || $urandom_range(0, 7) == 0) cut = $urandom_range(0, reply.size() - 1);
    for (int i = 0; i < cut; i++) begin
      send_noise(1'b0);
      it           = random_item(OP_RX_BYTE);
      it.data_byte = reply[i];
      send_item(it, 1'b0, '0);
    end
    if (!abandon && cut < reply.size()) begin
      send_item(random_item(OP_TIMEOUT), 1'b0, '0);
    end
  endtask

  // Main sequence: reset, directed table, random transactions, drain.
  initial begin
    item_t       it;
    int unsigned base_items;
    int unsigned n_txn;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    drv_item      = '0;
    drv_typed_on  = 1'b0;
    drv_typed_val = '0;
    fail_count    = 0;
    items_sent    = 0;
    calm          = 1'b0;
    txn_phase     = ST_IDLE;
    cmd_id        = '0;
    cmd_sum       = '0;
    params_due    = '0;
    reply_pos     = '0;
    reply_data_cnt = '0;
    reply_sum     = '0;
    reply_hdr_ok  = 1'b1;
    reply_id_ok   = 1'b1;
    reply_err     = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[r]) begin
      it              = '0;
      it.opcode       = directed_rows[r].op;
      it.target_id    = directed_rows[r].id;
      it.instruction  = directed_rows[r].ins;
      it.param_count  = directed_rows[r].pc;
      it.expect_count = directed_rows[r].ec;
      it.data_byte    = directed_rows[r].dbyte;
      send_item(it, directed_rows[r].typed_on, directed_rows[r].typed_res);
    end
    wait_for_drain();

    base_items = items_sent;
    n_txn      = 0;
    while (items_sent < base_items + 410) begin
      run_transaction();
      n_txn++;
      if (n_txn % 8 == 0) wait_for_drain();
    end

    calm = 1'b0;
    wait_for_drain();
    repeat (16) @(posedge clk_i);
    if (fail_count == 0 && due_outputs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/sbpe_pkg.sv
rtl/sbpe_txn.sv
rtl/servo_bus_packet_engine_core.sv
tb/testbench.sv
